// ----- hw/rtl/lfu_cache_lru_tiebreak_macros.svh -----
// Assertion macros for the LFU cache checker.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LFU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfu check failed: same cycle");

// Next-cycle implication, sampled on i_clk, off during reset.
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfu check failed: next cycle");

`endif

// ----- hw/rtl/lfu_pkg.sv -----
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 14;
    localparam int COUNT_BITS  = 16;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_BITS    = 5;
    localparam int CAP_RESET   = 16;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        UPD_NONE   = 2'd0,
        UPD_TOUCH  = 2'd1,
        UPD_INSERT = 2'd2
    } t_upd_op;

    typedef struct packed {
        logic                         kind;
        logic [KEY_BITS-1:0]          key;
        logic signed [VALUE_BITS-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic                         hit;
        logic signed [VALUE_BITS-1:0] read_value;
        logic                         evicted;
        logic [KEY_BITS-1:0]          evicted_key;
    } t_out_word;

    // Running result passed from cell to cell.
    typedef struct packed {
        logic                         match_found;
        logic [IDX_W-1:0]             match_idx;
        logic [IDX_W-1:0]             match_rank;
        logic signed [VALUE_BITS-1:0] match_value;
        logic                         free_found;
        logic [IDX_W-1:0]             free_idx;
        logic                         vic_found;
        logic [IDX_W-1:0]             vic_idx;
        logic [COUNT_BITS-1:0]        vic_cnt;
        logic [IDX_W-1:0]             vic_rank;
        logic [KEY_BITS-1:0]          vic_key;
    } t_carry;

    // Update broadcast to all cells on commit.
    typedef struct packed {
        t_upd_op                      op;
        logic [IDX_W-1:0]             idx;
        logic [IDX_W-1:0]             rank;
        logic                         wr_value;
        logic                         evict;
        logic [IDX_W-1:0]             vic_idx;
        logic [KEY_BITS-1:0]          key;
        logic signed [VALUE_BITS-1:0] value;
    } t_upd;

endpackage

// ----- hw/rtl/lfu_cell.sv -----
module lfu_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lfu_pkg::KEY_BITS-1:0]     i_key,
    input  lfu_pkg::t_carry                  i_carry,
    output lfu_pkg::t_carry                  o_carry,
    input  lfu_pkg::t_upd                    i_upd
);

    localparam logic [lfu_pkg::IDX_W-1:0] MY = lfu_pkg::IDX_W'(CELL_IDX);

    logic                                    r_valid;
    logic [lfu_pkg::KEY_BITS-1:0]            r_key;
    logic signed [lfu_pkg::VALUE_BITS-1:0]   r_value;
    logic [lfu_pkg::COUNT_BITS-1:0]          r_cnt;
    logic [lfu_pkg::IDX_W-1:0]               r_rank;
    lfu_pkg::t_carry                         r_carry;
    lfu_pkg::t_carry                         n_carry;

    always_comb begin
        n_carry = i_carry;
        if (!i_carry.match_found && r_valid && r_key == i_key) begin
            n_carry.match_found = 1'b1;
            n_carry.match_idx   = MY;
            n_carry.match_rank  = r_rank;
            n_carry.match_value = r_value;
        end
        if (!i_carry.free_found && !r_valid) begin
            n_carry.free_found = 1'b1;
            n_carry.free_idx   = MY;
        end
        // lowest count wins, oldest rank on a tie
        if (r_valid && (!i_carry.vic_found || r_cnt < i_carry.vic_cnt ||
                        (r_cnt == i_carry.vic_cnt && r_rank > i_carry.vic_rank))) begin
            n_carry.vic_found = 1'b1;
            n_carry.vic_idx   = MY;
            n_carry.vic_cnt   = r_cnt;
            n_carry.vic_rank  = r_rank;
            n_carry.vic_key   = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_upd.op)
                lfu_pkg::UPD_INSERT: begin
                    if (i_upd.idx == MY) begin
                        r_valid <= 1'b1;
                    end else if (i_upd.evict && i_upd.vic_idx == MY) begin
                        r_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_upd.op)
            lfu_pkg::UPD_TOUCH: begin
                if (i_upd.idx == MY) begin
                    r_rank <= '0;
                    if (r_cnt != '1) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (i_upd.wr_value) begin
                        r_value <= i_upd.value;
                    end
                end else if (r_valid && r_rank < i_upd.rank) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            lfu_pkg::UPD_INSERT: begin
                if (i_upd.idx == MY) begin
                    r_key   <= i_upd.key;
                    r_value <= i_upd.value;
                    r_cnt   <= lfu_pkg::COUNT_BITS'(1);
                    r_rank  <= '0;
                end else if (r_valid && !(i_upd.evict && i_upd.vic_idx == MY)) begin
                    // remove-then-age nets to no change above the victim rank
                    if (!(i_upd.evict && r_rank > i_upd.rank)) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/lfu_cache_lru_tiebreak.sv -----
// LFU cache with LRU tie break. Holds up to 16 key/value entries in a row of
// slot cells. Each word on the input channel is a get (kind 0) or put (kind 1)
// and yields exactly one result word: hit, read value on a get hit, and the
// evicted key when a put on a new key had to make room. Eviction takes the
// entry with the lowest use count, and among equal counts the least recently
// used. Counts saturate at all ones. The capacity register (reset 16, values
// above 16 act as 16, zero makes puts no-ops) is written through the cfg
// channel; the user must write it only while the cache is idle, as the block
// itself does not enforce this. Between accept and result, the probe key is
// broadcast to the cells, and the match, lowest-free and victim results
// ripple one cell per cycle through registers along the 16-cell chain, then
// the commit state updates the cells and loads the output register. The next
// word is taken the cycle after commit; a stalled result that is still
// waiting holds the commit. The output register frees the input side, so a
// new word is taken while a result still waits.
module lfu_cache_lru_tiebreak (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lfu_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lfu_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lfu_pkg::CAP_BITS-1:0]     i_cfg_data
);

    localparam int N     = lfu_pkg::MAX_ENTRIES;
    localparam int IDX_W = lfu_pkg::IDX_W;
    localparam int OCC_W = lfu_pkg::OCC_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [IDX_W-1:0]                    r_scan;
    logic [lfu_pkg::CAP_BITS-1:0]        r_cap;
    logic [OCC_W-1:0]                    r_occ;
    logic [OCC_W-1:0]                    n_occ;
    lfu_pkg::t_in_word                   r_item;
    logic                                r_ovalid;
    lfu_pkg::t_out_word                  r_oword;
    lfu_pkg::t_out_word                  n_oword;
    lfu_pkg::t_upd                       n_upd;

    lfu_pkg::t_carry                     w_carry [N+1];
    lfu_pkg::t_carry                     w_res;

    logic                                in_fire;
    logic                                commit_fire;
    logic                                cap_zero;
    logic [OCC_W-1:0]                    cap_eff;
    logic                                is_put;
    logic                                do_evict;
    logic                                do_insert;
    logic [IDX_W-1:0]                    ins_idx;

    assign in_fire     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign commit_fire = (r_state == ST_COMMIT) && (!r_ovalid || !i_out_stall);

    // ---- cell chain: cell i's carry register holds results over slots 0..i
    assign w_carry[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        lfu_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_item.key),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .i_upd   (n_upd)
        );
    end

    assign w_res = w_carry[N];

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan == IDX_W'(N - 1)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_scan <= r_scan + 1'b1;
            end else begin
                r_scan <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_word;
        end
    end

    // ---- commit decision
    assign cap_zero = (r_cap == '0);
    assign cap_eff  = (32'(r_cap) > 32'(N)) ? OCC_W'(N) : OCC_W'(r_cap);
    assign is_put   = r_item.kind;
    assign do_evict = is_put && !cap_zero && !w_res.match_found &&
                      (r_occ >= cap_eff) && w_res.vic_found;
    // victim's slot is free once it goes; lowest-numbered free slot wins
    assign ins_idx  = (do_evict && !(w_res.free_found && w_res.free_idx < w_res.vic_idx))
                      ? w_res.vic_idx : w_res.free_idx;
    assign do_insert = is_put && !cap_zero && !w_res.match_found &&
                       (do_evict || w_res.free_found);

    always_comb begin
        n_upd          = '0;
        n_upd.op       = lfu_pkg::UPD_NONE;
        n_upd.key      = r_item.key;
        n_upd.value    = r_item.value;
        n_upd.vic_idx  = w_res.vic_idx;
        if (commit_fire) begin
            if (w_res.match_found && (!is_put || !cap_zero)) begin
                n_upd.op       = lfu_pkg::UPD_TOUCH;
                n_upd.idx      = w_res.match_idx;
                n_upd.rank     = w_res.match_rank;
                n_upd.wr_value = is_put;
            end else if (do_insert) begin
                n_upd.op    = lfu_pkg::UPD_INSERT;
                n_upd.idx   = ins_idx;
                n_upd.evict = do_evict;
                n_upd.rank  = w_res.vic_rank;
            end
        end
    end

    always_comb begin
        n_oword             = '0;
        n_oword.hit         = w_res.match_found;
        n_oword.read_value  = (!is_put && w_res.match_found) ? w_res.match_value : '0;
        n_oword.evicted     = do_evict;
        n_oword.evicted_key = do_evict ? w_res.vic_key : '0;
    end

    always_comb begin
        n_occ = r_occ;
        if (do_insert && !do_evict) begin
            n_occ = r_occ + 1'b1;
        end
    end

    // ---- occupancy, capacity, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_cap    <= lfu_pkg::CAP_BITS'(lfu_pkg::CAP_RESET);
            r_ovalid <= 1'b0;
        end else begin
            if (commit_fire) begin
                r_occ <= n_occ;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (commit_fire) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_oword <= n_oword;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

endmodule

// ----- hw/rtl/lfu_checker.sv -----
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input lfu_pkg::t_out_word               o_out_word
);

    `LFU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `LFU_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)
    `LFU_ASSERT_NOW(a_evkey_zero, o_out_valid && !o_out_word.evicted,
                    o_out_word.evicted_key == '0)
    `LFU_ASSERT_NOW(a_evict_miss, o_out_valid && o_out_word.evicted, !o_out_word.hit)
    `LFU_ASSERT_NOW(a_read_hit, o_out_valid && o_out_word.read_value != '0,
                    o_out_word.hit)

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (.*);

// ----- tb/sv/tb_lfu_cache_lru_tiebreak.sv -----
module tb_lfu_cache_lru_tiebreak;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;
    localparam int   CAP_MAX_CODE = (1 << lfu_pkg::CAP_BITS) - 1;
    localparam logic [lfu_pkg::COUNT_BITS-1:0] COUNT_SAT = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    lfu_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    lfu_pkg::t_out_word o_out_word;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [lfu_pkg::CAP_BITS-1:0] i_cfg_data = '0;

    lfu_cache_lru_tiebreak dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Cache shadow: slot contents, use counts and recency ranks
    // (rank 0 = most recent). Updated when an input word is accepted.
    // ---------------------------------------------------------------
    logic                           shadow_valid [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::KEY_BITS-1:0]   shadow_key   [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::VALUE_BITS-1:0] shadow_value [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0] shadow_count [lfu_pkg::MAX_ENTRIES];
    int unsigned                    shadow_rank  [lfu_pkg::MAX_ENTRIES];
    int unsigned                    shadow_occ;
    int unsigned                    shadow_cap;

    lfu_pkg::t_in_word  pending_ops[$];      // words waiting for the driver
    lfu_pkg::t_out_word expected_results[$]; // predicted result words, oldest first
    int        fail_count = 0;
    bit        no_idle = 1'b0;      // final stretch runs without gaps or stalls

    function automatic void shadow_touch(int s);
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++)
            if (shadow_valid[i] && i != s && shadow_rank[i] < shadow_rank[s])
                shadow_rank[i]++;
        shadow_rank[s] = 0;
        if (shadow_count[s] != COUNT_SAT)
            shadow_count[s]++;
    endfunction

    // Lowest count wins; equal counts go to the oldest rank.
    function automatic int shadow_victim();
        int best;
        best = -1;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            if (!shadow_valid[i])
                continue;
            if (best < 0 || shadow_count[i] < shadow_count[best] ||
                (shadow_count[i] == shadow_count[best] &&
                 shadow_rank[i] > shadow_rank[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic lfu_pkg::t_out_word predict_cache_op(lfu_pkg::t_in_word w);
        lfu_pkg::t_out_word r;
        int          s;
        int          v;
        int          f;
        int unsigned c;
        r = '0;
        s = -1;
        f = -1;
        c = (shadow_cap > lfu_pkg::MAX_ENTRIES) ? lfu_pkg::MAX_ENTRIES : shadow_cap;
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++)
            if (s < 0 && shadow_valid[i] && shadow_key[i] == w.key)
                s = i;
        r.hit = (s >= 0);
        if (w.kind == OP_GET) begin
            if (s >= 0) begin
                shadow_touch(s);
                r.read_value = shadow_value[s];
            end
        end else if (c > 0) begin
            if (s >= 0) begin
                shadow_value[s] = w.value;
                shadow_touch(s);
            end else begin
                if (shadow_occ >= c) begin
                    v = shadow_victim();
                    if (v >= 0) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = shadow_key[v];
                        shadow_valid[v] = 1'b0;
                        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++)
                            if (shadow_valid[i] && shadow_rank[i] > shadow_rank[v])
                                shadow_rank[i]--;
                        if (shadow_occ > 0)
                            shadow_occ--;
                    end
                end
                for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++)
                    if (f < 0 && !shadow_valid[i])
                        f = i;
                if (f >= 0) begin
                    for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++)
                        if (shadow_valid[i])
                            shadow_rank[i]++;
                    shadow_valid[f] = 1'b1;
                    shadow_key[f]   = w.key;
                    shadow_value[f] = w.value;
                    shadow_count[f] = 1;
                    shadow_rank[f]  = 0;
                    shadow_occ++;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint expv, longint gotv);
        $display("mismatch %s: expected %0h got %0h at %0t", what, expv, gotv, $realtime);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Input driver: holds a presented word until accepted, random gaps.
    // ---------------------------------------------------------------
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(predict_cache_op(i_in_word));
            if (i_in_valid && o_in_stall) begin
                // stalled word stays put
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() > 0 &&
                         (no_idle || $urandom_range(0, 4) != 0)) begin
                i_in_word  <= pending_ops.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                if (!no_idle && pending_ops.size() > 0)
                    in_gap <= $urandom_range(0, 2);
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor and stall generator.
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        lfu_pkg::t_out_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word", 0, 1);
            end else begin
                exp_word = expected_results.pop_front();
                if (o_out_word.hit !== exp_word.hit)
                    report_mismatch("hit", longint'(exp_word.hit),
                                    longint'(o_out_word.hit));
                if (o_out_word.read_value !== exp_word.read_value)
                    report_mismatch("read_value", longint'(exp_word.read_value),
                                    longint'(o_out_word.read_value));
                if (o_out_word.evicted !== exp_word.evicted)
                    report_mismatch("evicted", longint'(exp_word.evicted),
                                    longint'(o_out_word.evicted));
                if (o_out_word.evicted_key !== exp_word.evicted_key)
                    report_mismatch("evicted_key", longint'(exp_word.evicted_key),
                                    longint'(o_out_word.evicted_key));
            end
        end
        if (no_idle) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void queue_op(logic kind, logic [lfu_pkg::KEY_BITS-1:0] key,
                                     logic [lfu_pkg::VALUE_BITS-1:0] value);
        lfu_pkg::t_in_word w;
        w.kind  = kind;
        w.key   = key;
        w.value = value;
        pending_ops.push_back(w);
    endfunction

    // Mostly a small key pool so hits, ties and evictions are frequent.
    function automatic void queue_random_ops(int n, int pool);
        int sel;
        logic [lfu_pkg::KEY_BITS-1:0] k;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 19);
            if (sel < 15)
                k = lfu_pkg::KEY_BITS'($urandom_range(0, pool));
            else if (sel < 17)
                k = lfu_pkg::KEY_BITS'((1 << lfu_pkg::KEY_BITS) - 1 - $urandom_range(0, 3));
            else
                k = lfu_pkg::KEY_BITS'($urandom);
            queue_op(($urandom_range(0, 9) < 4) ? OP_PUT : OP_GET, k, $urandom);
        end
    endfunction

    // Waits until every word is out and the pipeline has drained.
    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_capacity(int unsigned cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap[lfu_pkg::CAP_BITS-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_cap = cap;
    endtask

    int unsigned cap_plan[] = '{0, CAP_MAX_CODE, 1, 5, 2, 16, 0, 7, 3, 12, 16};

    initial begin
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_count[i] = '0;
            shadow_rank[i]  = 0;
        end
        shadow_occ = 0;
        shadow_cap = lfu_pkg::CAP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset capacity: key extremes, value extremes, overwrite,
        // a miss, then fill past capacity so an equal-count tie is evicted.
        queue_op(OP_GET, 0, 32'h1234_5678);
        queue_op(OP_PUT, 0, 32'h8000_0000);
        queue_op(OP_PUT, 16383, 32'h7fff_ffff);
        queue_op(OP_GET, 16383, 0);
        queue_op(OP_PUT, 0, 32'hffff_ffff);
        queue_op(OP_GET, 0, 0);
        queue_op(OP_GET, 100, 0);
        for (int k = 1; k <= 15; k++)
            queue_op(OP_PUT, lfu_pkg::KEY_BITS'(k * 1000), lfu_pkg::VALUE_BITS'(k));
        queue_op(OP_PUT, 42, 42);       // full: all other count-1 entries tie
        queue_op(OP_PUT, 43, 43);
        wait_drained();

        // Directed, capacity zero: puts change nothing but still report hit.
        write_capacity(0);
        queue_op(OP_PUT, 0, 5);
        queue_op(OP_PUT, 777, 6);
        queue_op(OP_GET, 0, 0);
        queue_op(OP_GET, 777, 0);
        wait_drained();

        // Random phases across capacity settings, including lowering it
        // below the current fill level.
        for (int p = 0; p < cap_plan.size(); p++) begin
            write_capacity(cap_plan[p]);
            if (p == cap_plan.size() - 1)
                no_idle = 1'b1;
            queue_random_ops(125, (cap_plan[p] > 0 && cap_plan[p] < 8) ?
                             2 * cap_plan[p] + 2 : 24);
            wait_drained();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
